// ===== rtl/pitch_change_segmenter_assert.svh =====
// Assertion macros shared by the pitch change segmenter RTL.
// Each expects clk_i and rst_ni (active low) in the scope where it is used.
`ifndef PITCH_CHANGE_SEGMENTER_ASSERT_SVH
`define PITCH_CHANGE_SEGMENTER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define PCS_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequence that must hold at the clock after the antecedent.
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Consequence that must hold in the same clock as the antecedent.
`define PCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pcs_pkg.sv =====
// Package of the pitch change segmenter: result type, queue size and constants.
// No dependencies; used by the interfaces, the result queue and the top level.
package pcs_pkg;

  // Default parameter values.
  localparam int unsigned PitchBitsDefault    = 18;
  localparam int unsigned PositionBitsDefault = 32;

  // Field widths of the channels and registers.
  localparam int unsigned PitchInBits   = 18;
  localparam int unsigned SampleOutBits = 32;
  localparam int unsigned CfgIndexBits  = 2;
  localparam int unsigned CfgDataBits   = 16;
  localparam int unsigned RunBits       = 5;
  localparam int unsigned MinRunBits    = 4;

  // Register indexes of the configuration port.
  localparam logic [CfgIndexBits-1:0] CFG_FRAME_SAMPLES  = 2'd0;
  localparam logic [CfgIndexBits-1:0] CFG_MIN_RUN_FRAMES = 2'd1;

  // Register reset values.
  localparam logic [CfgDataBits-1:0] FrameSamplesReset = 16'd705;
  localparam logic [MinRunBits-1:0]  MinRunReset       = 4'd10;

  // Run counter limits.
  localparam logic [RunBits-1:0] RunReset = 5'd4;
  localparam logic [RunBits-1:0] RunMax   = 5'd31;

  // Result queue depth; must be a power of two of at least two.
  localparam int unsigned ResultDepth = 4;

  // One emitted segment.
  typedef struct packed {
    logic [SampleOutBits-1:0] seg_first_sample;
    logic [SampleOutBits-1:0] seg_last_sample;
    logic                     run_end;
  } pcs_result_t;

  // Push control from the segmenter core into the result queue.
  typedef struct packed {
    logic first;
    logic second;
  } pcs_push_t;

endpackage

// ===== rtl/pcs_stream_if.sv =====
// Valid/ready channel interfaces of the pitch change segmenter.
// Depends on pcs_pkg for the field widths.
interface pcs_in_if;
  import pcs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [PitchInBits-1:0] frame_pitch;
  logic                   final_frame;

  modport source (output valid, output frame_pitch, output final_frame, input ready);
  modport sink (input valid, input frame_pitch, input final_frame, output ready);
endinterface

interface pcs_out_if;
  import pcs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [SampleOutBits-1:0] seg_first_sample;
  logic [SampleOutBits-1:0] seg_last_sample;
  logic                     run_end;

  modport source (output valid, output seg_first_sample, output seg_last_sample,
                  output run_end, input ready);
  modport sink (input valid, input seg_first_sample, input seg_last_sample,
                input run_end, output ready);
endinterface

// ===== rtl/pcs_result_fifo.sv =====
// Result queue of the pitch change segmenter: takes up to two segments a clock.
// Depends on pcs_pkg and the pcs_out_if interface; drives the output channel.
module pcs_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcs_pkg::pcs_push_t  push_i,
  input  pcs_pkg::pcs_result_t first_i,
  input  pcs_pkg::pcs_result_t second_i,
  output logic                room_o,
  pcs_out_if.source           seg_o
);
  import pcs_pkg::*;

  localparam int unsigned PtrW = $clog2(ResultDepth);
  localparam int unsigned CntW = $clog2(ResultDepth + 1);

  pcs_result_t          mem_q [ResultDepth];
  logic [PtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [PtrW-1:0]      wr_next;
  logic [CntW-1:0]      push_n;
  logic                 pop;

  // Handshake on the output side and the number of entries pushed.
  assign pop     = seg_o.valid && seg_o.ready;
  assign push_n  = CntW'(push_i.first) + CntW'(push_i.second);
  assign wr_next = wr_q + PtrW'(1);

  // Pointer and fill count updates.
  always_comb begin
    wr_d  = wr_q + PtrW'(push_n);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + push_n - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage; the second segment lands behind the first.
  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_q] <= first_i;
    end
    if (push_i.second) begin
      mem_q[wr_next] <= second_i;
    end
  end

  // Room for a full beat of two segments.
  assign room_o = (cnt_q <= CntW'(ResultDepth - 2));

  // Head of the queue drives the output channel.
  assign seg_o.valid            = (cnt_q != '0);
  assign seg_o.seg_first_sample = mem_q[rd_q].seg_first_sample;
  assign seg_o.seg_last_sample  = mem_q[rd_q].seg_last_sample;
  assign seg_o.run_end          = mem_q[rd_q].run_end;

`include "pitch_change_segmenter_assert.svh"

  `PCS_ASSERT_NOW(a_cnt_in_range, cnt_q <= CntW'(ResultDepth), "result queue overfilled")
  `PCS_ASSERT_SAME(a_second_needs_first, push_i.second, push_i.first, "second push alone")
  `PCS_ASSERT_SAME(a_push_has_room, push_i.first, room_o, "push without room")
  `PCS_ASSERT_NEXT(a_pop_drains, pop && !push_i.first, cnt_q == $past(cnt_q) - CntW'(1),
                   "fill count lost a pop")

endmodule

// ===== rtl/pitch_change_segmenter.sv =====
// Top level of the pitch change segmenter: pitch window, boundary test, counters.
// Depends on pcs_pkg, the pcs_stream_if interfaces and pcs_result_fifo.
//
// Usage: frame_i carries one beat per audio frame (frame_pitch in Hz and the
// final_frame flag); seg_o carries one beat per emitted segment (first and last
// sample index, and run_end on the last segment caused by a frame). The two
// registers (frame_samples, min_run_frames) are written through cfg_we_i,
// cfg_index_i and cfg_wdata_i while the block is idle.
// Throughput: one frame per clock unless the queue lacks room. The boundary test
// over the seven-deep window and all counter updates are done in the accepting clock.
// Output: a frame's segments enter the result queue at the frame beat and are
// offered on seg_o from its head. A frame yields zero, one or two segments.
// Stall: segments wait in a four-entry result queue; frame_i.ready is low
// while the queue holds more than two segments, so it stays high as long as
// the receiver takes segments at the rate they are made.
// Reset: the window and counters take their reset values, the registers go to
// 705 samples per frame and a minimum run of ten frames, and the queue empties.
// A final frame returns the window and counters to their reset values.
module pitch_change_segmenter #(
  parameter int unsigned PITCH_BITS    = pcs_pkg::PitchBitsDefault,
  parameter int unsigned POSITION_BITS = pcs_pkg::PositionBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcs_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [pcs_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  pcs_in_if.sink                           frame_i,
  pcs_out_if.source                        seg_o
);
  import pcs_pkg::*;

  localparam int unsigned MulW = PITCH_BITS + 4;
  localparam int unsigned InW  = (PITCH_BITS > PitchInBits) ? PITCH_BITS : PitchInBits;
  localparam int unsigned TriW = (POSITION_BITS > 18) ? POSITION_BITS : 18;
  localparam int unsigned OutW = (POSITION_BITS > SampleOutBits) ? POSITION_BITS
                                                                 : SampleOutBits;

  // Two pitches differ when they are more than ten percent apart.
  function automatic logic differs(input logic [PITCH_BITS-1:0] a,
                                   input logic [PITCH_BITS-1:0] b);
    logic [MulW-1:0] a10;
    logic [MulW-1:0] b9;
    logic [MulW-1:0] b11;
    a10 = (MulW'(a) << 3) + (MulW'(a) << 1);
    b9  = (MulW'(b) << 3) + MulW'(b);
    b11 = (MulW'(b) << 3) + (MulW'(b) << 1) + MulW'(b);
    return (a10 < b9) || (a10 > b11);
  endfunction

  // Configuration registers.
  logic [CfgDataBits-1:0] fs_q;
  logic [MinRunBits-1:0]  minrun_q;

  // Segmenter state.
  logic [PITCH_BITS-1:0]    win_q [7];
  logic [PITCH_BITS-1:0]    win_d [7];
  logic [2:0]               seen_q, seen_d;
  logic [RunBits-1:0]       run_q, run_d;
  logic [POSITION_BITS-1:0] open_q, open_d;
  logic [POSITION_BITS-1:0] chk_q, chk_d;

  logic                     accept;
  logic                     fin;
  logic [InW-1:0]           pin_w;
  logic [PITCH_BITS-1:0]    pitch;
  logic [TriW-1:0]          fs_w;
  logic [TriW-1:0]          tri_w;
  logic [POSITION_BITS-1:0] three_n;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] last;
  logic                     check;
  logic                     is_boundary;
  logic                     long_run;
  logic                     emit_fin;
  logic                     emit_bnd;
  logic [OutW-1:0]          open_w;
  logic [OutW-1:0]          last_w;
  logic                     room;
  pcs_push_t                push;
  pcs_result_t              res_first;
  pcs_result_t              res_second;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q     <= FrameSamplesReset;
      minrun_q <= MinRunReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_SAMPLES:  fs_q     <= cfg_wdata_i;
        CFG_MIN_RUN_FRAMES: minrun_q <= cfg_wdata_i[MinRunBits-1:0];
        default: ;
      endcase
    end
  end

  // Input beat and pitch field.
  assign accept = frame_i.valid && frame_i.ready;
  assign fin    = frame_i.final_frame;
  assign pin_w  = InW'(frame_i.frame_pitch);
  assign pitch  = pin_w[PITCH_BITS-1:0];

  // Sample position of the frame under test; reloaded at a recording's start.
  assign fs_w    = TriW'(fs_q);
  assign tri_w   = (fs_w << 1) + fs_w;
  assign three_n = tri_w[POSITION_BITS-1:0];
  assign pos     = (seen_q == 3'd0) ? three_n : chk_q;
  assign last    = pos - POSITION_BITS'(1);

  // Boundary test on the middle of the window, once the window is full.
  assign check       = (seen_q == 3'd7);
  assign is_boundary = differs(win_q[3], win_q[2]) && differs(win_q[3], win_q[1]) &&
                       differs(win_q[3], win_q[0]) && differs(win_q[2], win_q[4]) &&
                       differs(win_q[2], win_q[5]) && differs(win_q[2], win_q[6]);
  assign long_run    = (run_q > RunBits'(minrun_q));
  assign emit_fin    = accept && check && fin && long_run;
  assign emit_bnd    = accept && check && is_boundary && long_run;

  // Next state of the window and counters.
  always_comb begin
    win_d  = win_q;
    seen_d = seen_q;
    run_d  = run_q;
    open_d = open_q;
    chk_d  = chk_q;
    if (accept) begin
      if (fin) begin
        for (int k = 0; k < 7; k++) begin
          win_d[k] = '0;
        end
        seen_d = 3'd0;
        run_d  = RunReset;
        open_d = '0;
        chk_d  = three_n;
      end else begin
        for (int k = 0; k < 6; k++) begin
          win_d[k] = win_q[k+1];
        end
        win_d[6] = pitch;
        if (seen_q != 3'd7) begin
          seen_d = seen_q + 3'd1;
        end
        if (check) begin
          if (is_boundary) begin
            open_d = pos;
            run_d  = RunBits'(1);
          end else if (run_q != RunMax) begin
            run_d = run_q + RunBits'(1);
          end
          chk_d = pos + POSITION_BITS'(fs_q);
        end else begin
          chk_d = pos;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 7; k++) begin
        win_q[k] <= '0;
      end
      seen_q <= 3'd0;
      run_q  <= RunReset;
      open_q <= '0;
      chk_q  <= '0;
    end else begin
      win_q  <= win_d;
      seen_q <= seen_d;
      run_q  <= run_d;
      open_q <= open_d;
      chk_q  <= chk_d;
    end
  end

  // Both possible results name the same open segment; run_end marks the last.
  assign open_w = OutW'(open_q);
  assign last_w = OutW'(last);

  always_comb begin
    push.first                  = emit_fin || emit_bnd;
    push.second                 = emit_fin && emit_bnd;
    res_first.seg_first_sample  = open_w[SampleOutBits-1:0];
    res_first.seg_last_sample   = last_w[SampleOutBits-1:0];
    res_first.run_end           = !(emit_fin && emit_bnd);
    res_second.seg_first_sample = open_w[SampleOutBits-1:0];
    res_second.seg_last_sample  = last_w[SampleOutBits-1:0];
    res_second.run_end          = 1'b1;
  end

  // Result queue between the core and the output channel.
  pcs_result_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .first_i  (res_first),
    .second_i (res_second),
    .room_o   (room),
    .seg_o    (seg_o)
  );

  assign frame_i.ready = room;

`include "pitch_change_segmenter_assert.svh"

  `PCS_ASSERT_NEXT(a_final_clears, accept && fin,
                   seen_q == 3'd0 && run_q == RunReset && open_q == '0,
                   "state not cleared after final frame")
  `PCS_ASSERT_NOW(a_run_nonzero, run_q != '0, "run counter reached zero")
  `PCS_ASSERT_NEXT(a_boundary_opens, accept && check && is_boundary && !fin,
                   open_q == $past(pos) && run_q == RunBits'(1),
                   "boundary did not open a new segment")

endmodule

// ===== tb/tb_pitch_change_segmenter.sv =====
// Self-checking testbench of pitch_change_segmenter: directed table, then random recordings.
// Depends on pcs_pkg, the pcs_in_if/pcs_out_if interfaces and the RTL top level.
// Each segment beat is checked against typed-in values or an in-bench boundary model.
module tb_pitch_change_segmenter;
  timeunit 1ns;
  timeprecision 1ps;
  import pcs_pkg::*;

  localparam int unsigned PitchMax     = (1 << PitchInBits) - 1;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomFrames = 1950;
  localparam int unsigned PhaseFrames  = 150;
  localparam int unsigned GapPercent   = 17;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned HoldCycles   = 300;

  // Register indexes past the end of the register list; writes to them are dropped.
  localparam logic [CfgIndexBits-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIndexBits-1:0] CFG_SPARE_B = 2'd3;

  typedef logic [PitchInBits-1:0]   pitch_t;
  typedef logic [SampleOutBits-1:0] sample_t;

  typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_e;

  // One row of the directed table: a register write or a frame, with typed-in segments.
  typedef struct packed {
    row_kind_e                kind;
    logic [CfgIndexBits-1:0]  index;
    logic [CfgDataBits-1:0]   wdata;
    pitch_t                   pitch;
    logic                     last_frame;
    logic                     typed;
    logic [1:0]               n_segs;
    sample_t                  first0;
    sample_t                  last0;
    sample_t                  first1;
    sample_t                  last1;
  } stim_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we;
  logic [CfgIndexBits-1:0] cfg_index;
  logic [CfgDataBits-1:0]  cfg_wdata;

  pcs_in_if  frame_if ();
  pcs_out_if seg_if ();

  pitch_change_segmenter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .frame_i     (frame_if),
    .seg_o       (seg_if)
  );

  // Model of the segmenter: registers, pitch window and counters.
  logic [CfgDataBits-1:0] cur_frame_samples;
  logic [MinRunBits-1:0]  cur_min_run;
  pitch_t                 win_pitch [7];
  logic [31:0]            frames_in_rec;
  logic [RunBits-1:0]     run_len;
  sample_t                seg_start;
  sample_t                check_pos;

  pcs_result_t pending_segments [$];
  stim_row_t   stim_rows [$];

  int unsigned errors;
  int unsigned cycle_count;
  int unsigned frames_sent;
  int unsigned hold_left;
  bit          no_gaps;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Two pitches differ when more than ten percent apart, in exact integer form.
  function automatic bit pitches_differ(input pitch_t a, input pitch_t b);
    int unsigned ta;
    int unsigned lo;
    int unsigned hi;
    ta = 10 * int'(a);
    lo = 9 * int'(b);
    hi = 11 * int'(b);
    return (ta < lo) || (ta > hi);
  endfunction

  // Append one expected segment behind those already outstanding.
  function automatic void expect_segment(input pcs_result_t seg);
    pending_segments.insert(pending_segments.size(), seg);
  endfunction

  // Start of a recording: window, counters and positions go back to their reset values.
  task automatic clear_recording();
    for (int k = 0; k < 7; k++) win_pitch[k] = '0;
    frames_in_rec = '0;
    run_len       = RunReset;
    seg_start     = '0;
    check_pos     = 32'(cur_frame_samples) * 3;
  endtask

  // Advance the model by one frame and queue the segments it closes.
  task automatic segment_frame(input pitch_t p, input logic last_frame, input bit typed);
    pcs_result_t made [2];
    sample_t     pos;
    bit          boundary;
    int          n;
    n = 0;
    if (frames_in_rec == 0) check_pos = 32'(cur_frame_samples) * 3;
    if (frames_in_rec >= 7) begin
      // win_pitch[3] is the checked frame, with three neighbors on each side.
      pos = check_pos;
      boundary = pitches_differ(win_pitch[3], win_pitch[2]) &&
                 pitches_differ(win_pitch[3], win_pitch[1]) &&
                 pitches_differ(win_pitch[3], win_pitch[0]) &&
                 pitches_differ(win_pitch[2], win_pitch[4]) &&
                 pitches_differ(win_pitch[2], win_pitch[5]) &&
                 pitches_differ(win_pitch[2], win_pitch[6]);
      if (last_frame && run_len > cur_min_run) begin
        made[n] = '{seg_first_sample: seg_start, seg_last_sample: pos - 32'd1, run_end: 1'b0};
        n++;
      end
      if (boundary) begin
        if (run_len > cur_min_run) begin
          made[n] = '{seg_first_sample: seg_start, seg_last_sample: pos - 32'd1, run_end: 1'b0};
          n++;
        end
        seg_start = pos;
        run_len   = '0;
      end
      if (run_len < RunMax) run_len++;
      check_pos = pos + 32'(cur_frame_samples);
    end
    for (int k = 0; k < 6; k++) win_pitch[k] = win_pitch[k + 1];
    win_pitch[6] = p;
    if (frames_in_rec != 32'hFFFF_FFFF) frames_in_rec++;
    if (last_frame) clear_recording();
    if (n > 0) made[n - 1].run_end = 1'b1;
    if (!typed) begin
      for (int k = 0; k < n; k++) expect_segment(made[k]);
    end
  endtask

  // Offer one frame beat, with random gaps, and update the model when it is taken.
  task automatic send_frame(input pitch_t p, input logic last_frame, input bit typed);
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < GapPercent) begin
      frame_if.valid = 1'b0;
      @(negedge clk_i);
    end
    frame_if.valid       = 1'b1;
    frame_if.frame_pitch = p;
    frame_if.final_frame = last_frame;
    @(posedge clk_i);
    while (!frame_if.ready) @(posedge clk_i);
    segment_frame(p, last_frame, typed);
    frames_sent++;
  endtask

  // Stop offering frames and wait until every queued segment has come out.
  task automatic wait_idle();
    @(negedge clk_i);
    frame_if.valid = 1'b0;
    while (pending_segments.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register write; the model takes it at the same edge as the block.
  task automatic cfg_write(input logic [CfgIndexBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk_i);
    case (idx)
      CFG_FRAME_SAMPLES:  cur_frame_samples = data;
      CFG_MIN_RUN_FRAMES: cur_min_run = data[MinRunBits-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // A recording of steady-pitch stretches with small jitter and the odd stray frame.
  task automatic play_recording(input int len, input bit close);
    int          left;
    int unsigned base;
    int unsigned p;
    base = $urandom_range(0, PitchMax);
    left = $urandom_range(1, 20);
    for (int k = 0; k < len; k++) begin
      if (left == 0) begin
        case ($urandom_range(9))
          0, 1:    base = $urandom_range(0, PitchMax);
          2:       base = $urandom_range(0, 255);
          3, 4, 5: base = base * $urandom_range(50, 200) / 100;
          6, 7, 8: base = base * ($urandom_range(1) ? $urandom_range(108, 112)
                                                    : $urandom_range(88, 92)) / 100;
          default: base = 0;
        endcase
        if (base > PitchMax) base = PitchMax;
        left = ($urandom_range(9) == 0) ? $urandom_range(21, 40) : $urandom_range(1, 20);
      end
      if ($urandom_range(99) < 4) p = $urandom_range(0, PitchMax);
      else p = base * $urandom_range(97, 103) / 100;
      if (p > PitchMax) p = PitchMax;
      send_frame(pitch_t'(p), close && (k == len - 1), 1'b0);
      left--;
    end
  endtask

  task automatic add_frame(input pitch_t p, input logic last_frame, input logic [1:0] n_segs,
                           input sample_t f0, input sample_t l0,
                           input sample_t f1, input sample_t l1);
    stim_row_t row;
    row = '0;
    row.kind       = ROW_FRAME;
    row.pitch      = p;
    row.last_frame = last_frame;
    row.typed      = 1'b1;
    row.n_segs     = n_segs;
    row.first0     = f0;
    row.last0      = l0;
    row.first1     = f1;
    row.last1      = l1;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  task automatic add_cfg(input logic [CfgIndexBits-1:0] idx, input logic [CfgDataBits-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind  = ROW_CFG;
    row.index = idx;
    row.wdata = data;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  // Receiver: random stalls, a long hold-off on request, none in gap-free phases.
  initial begin
    seg_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        seg_if.ready = 1'b0;
        hold_left--;
      end else begin
        seg_if.ready = no_gaps || ($urandom_range(99) >= GapPercent);
      end
    end
  end

  // Compare each segment beat with the oldest expectation.
  always @(posedge clk_i) begin
    pcs_result_t want;
    if (rst_ni && seg_if.valid && seg_if.ready) begin
      if (pending_segments.size() == 0) begin
        $display("%0t: unexpected segment first=%0d last=%0d run_end=%0b", $time,
                 seg_if.seg_first_sample, seg_if.seg_last_sample, seg_if.run_end);
        errors++;
      end else begin
        want = pending_segments.pop_front();
        if (seg_if.seg_first_sample !== want.seg_first_sample) begin
          $display("%0t: seg_first_sample expected %0d actual %0d", $time,
                   want.seg_first_sample, seg_if.seg_first_sample);
          errors++;
        end
        if (seg_if.seg_last_sample !== want.seg_last_sample) begin
          $display("%0t: seg_last_sample expected %0d actual %0d", $time,
                   want.seg_last_sample, seg_if.seg_last_sample);
          errors++;
        end
        if (seg_if.run_end !== want.run_end) begin
          $display("%0t: run_end expected %0b actual %0b", $time,
                   want.run_end, seg_if.run_end);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d segments outstanding", $time, pending_segments.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus: reset, directed table, then random phases under changing registers.
  initial begin : stimulus
    stim_row_t              row;
    pcs_result_t            seg;
    logic [CfgDataBits-1:0] fs_w;
    logic [CfgDataBits-1:0] mr_w;
    int                     phase;
    int unsigned            phase_start;
    errors               = 0;
    cycle_count          = 0;
    frames_sent          = 0;
    hold_left            = 0;
    no_gaps              = 1'b0;
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_FRAME_SAMPLES;
    cfg_wdata            = '0;
    frame_if.valid       = 1'b0;
    frame_if.frame_pitch = '0;
    frame_if.final_frame = 1'b0;
    cur_frame_samples    = FrameSamplesReset;
    cur_min_run          = MinRunReset;
    clear_recording();

    // Short recording: never reaches a checked frame.
    add_frame(pitch_t'(PitchMax), 1'b0, 2'd0, '0, '0, '0, '0);
    add_frame('0, 1'b1, 2'd0, '0, '0, '0, '0);
    // Registers at reset: a boundary after a four-frame run is below the minimum of ten.
    repeat (3) add_frame(pitch_t'(1), 1'b0, 2'd0, '0, '0, '0, '0);
    repeat (4) add_frame(pitch_t'(PitchMax), 1'b0, 2'd0, '0, '0, '0, '0);
    add_frame(pitch_t'(PitchMax), 1'b1, 2'd0, '0, '0, '0, '0);
    // Every run long enough, widest frame.
    add_cfg(CFG_MIN_RUN_FRAMES, '0);
    add_cfg(CFG_FRAME_SAMPLES, 16'hFFFF);
    // Steady pitch: the final frame closes the only segment at the first checked frame.
    repeat (7) add_frame(pitch_t'(1000), 1'b0, 2'd0, '0, '0, '0, '0);
    add_frame(pitch_t'(1000), 1'b1, 2'd1, '0, 32'd196604, '0, '0);
    // Zero against full-scale pitch on the final check: the same segment comes out twice.
    repeat (3) add_frame('0, 1'b0, 2'd0, '0, '0, '0, '0);
    repeat (4) add_frame(pitch_t'(PitchMax), 1'b0, 2'd0, '0, '0, '0, '0);
    add_frame(pitch_t'(PitchMax), 1'b1, 2'd2, '0, 32'd196604, '0, 32'd196604);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        cfg_write(row.index, row.wdata);
      end else begin
        send_frame(row.pitch, row.last_frame, row.typed);
        for (int k = 0; k < row.n_segs; k++) begin
          seg.seg_first_sample = (k == 0) ? row.first0 : row.first1;
          seg.seg_last_sample  = (k == 0) ? row.last0 : row.last1;
          seg.run_end          = (k == row.n_segs - 1);
          expect_segment(seg);
        end
      end
    end

    // Random phases; a recording left open at the end of one runs on into the next.
    frames_sent = 0;
    phase = 0;
    while (frames_sent < RandomFrames) begin
      wait_idle();
      case (phase)
        0: begin fs_w = 16'd1;             mr_w = 16'd15; end
        1: begin fs_w = 16'hFFFF;          mr_w = 16'd0;  end
        2: begin fs_w = 16'd0;             mr_w = 16'($urandom_range(0, 15)); end
        4: begin fs_w = FrameSamplesReset; mr_w = 16'd0;  end
        default: begin
          case ($urandom_range(4))
            0:       fs_w = 16'd0;
            1:       fs_w = 16'd1;
            2:       fs_w = 16'hFFFF;
            3:       fs_w = FrameSamplesReset;
            default: fs_w = 16'($urandom_range(0, 16'hFFFF));
          endcase
          mr_w = 16'($urandom_range(0, 16'hFFFF));
        end
      endcase
      cfg_write(CFG_FRAME_SAMPLES, fs_w);
      cfg_write(CFG_MIN_RUN_FRAMES, mr_w);
      if ($urandom_range(2) == 0) begin
        cfg_write($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B,
                  16'($urandom_range(0, 16'hFFFF)));
      end
      no_gaps = (phase % 5 == 3);
      phase_start = frames_sent;
      if (phase == 4) begin
        // Receiver holds off while four-frame blocks keep closing segments.
        hold_left = HoldCycles;
        for (int k = 0; k < 80; k++) begin
          send_frame(((k / 4) % 2) ? pitch_t'(200000) : pitch_t'(1000), k == 79, 1'b0);
        end
      end else begin
        while (frames_sent - phase_start < PhaseFrames) begin
          play_recording(($urandom_range(9) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 80),
                         $urandom_range(7) != 0);
          if ($urandom_range(5) == 0) wait_idle();
        end
      end
      phase++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
